[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the decoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Check that a consequent follows an antecedent in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Check that a consequent follows an antecedent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/qepd_pkg.sv]
// ----------------------------------------------------------------------------
// qepd_pkg
// Shared constants, codes and the arctangent table of the pose decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qepd_pkg;

	// CORDIC iteration count default and table limit
	localparam int CORDIC_ITER_DEF = 16;
	localparam int CORDIC_ITER_MAX = 24;

	// atan2 operand width (Q4.28 values times two) and angle width (Q2.30)
	localparam int VEC_W = 34;
	localparam int ANG_W = 34;

	localparam logic        [31:0]      PI_Q30      = 32'd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [VEC_W-1:0] ONE_Q28     = 34'sd268435456;

	// Notification kinds carried in tuser
	typedef enum logic [1:0] {
		FUNC_IMU   = 2'd0,
		FUNC_EVENT = 2'd1,
		FUNC_BATT  = 2'd2,
		FUNC_OTHER = 2'd3
	} func_t;

	// Classifier event kinds
	localparam logic [7:0] EVK_SYNCED      = 8'd1;
	localparam logic [7:0] EVK_UNSYNCED    = 8'd2;
	localparam logic [7:0] EVK_POSE        = 8'd3;
	localparam logic [7:0] EVK_UNLOCKED    = 8'd4;
	localparam logic [7:0] EVK_LOCKED      = 8'd5;
	localparam logic [7:0] EVK_SYNC_FAILED = 8'd6;

	// Pose codes
	localparam logic [15:0] POSE_REST    = 16'h0000;
	localparam logic [15:0] POSE_FIRST   = 16'h0001;
	localparam logic [15:0] POSE_LAST    = 16'h0005;
	localparam logic [15:0] POSE_UNKNOWN = 16'hFFFF;

	// Minimum payload lengths and battery ceiling
	localparam logic [4:0] IMU_MIN_LEN = 5'd20;
	localparam logic [4:0] EVT_MIN_LEN = 5'd3;
	localparam logic [6:0] BATT_MAX    = 7'd100;

	// Floored arctan(2^-i) in Q2.30
	function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h3243F6A8;
			5'd1:  v = 32'h1DAC6705;
			5'd2:  v = 32'h0FADBAFC;
			5'd3:  v = 32'h07F56EA6;
			5'd4:  v = 32'h03FEAB76;
			5'd5:  v = 32'h01FFD55B;
			5'd6:  v = 32'h00FFFAAA;
			5'd7:  v = 32'h007FFF55;
			5'd8:  v = 32'h003FFFEA;
			5'd9:  v = 32'h001FFFFD;
			5'd10: v = 32'h000FFFFF;
			5'd11: v = 32'h0007FFFF;
			5'd12: v = 32'h0003FFFF;
			5'd13: v = 32'h0001FFFF;
			5'd14: v = 32'h0000FFFF;
			5'd15: v = 32'h00007FFF;
			5'd16: v = 32'h00003FFF;
			5'd17: v = 32'h00001FFF;
			5'd18: v = 32'h00000FFF;
			5'd19: v = 32'h000007FF;
			5'd20: v = 32'h000003FF;
			5'd21: v = 32'h000001FF;
			5'd22: v = 32'h000000FF;
			5'd23: v = 32'h0000007F;
			default: v = 32'h0;
		endcase
		return $signed({2'b00, v});
	endfunction

endpackage

`default_nettype wire

[rtl/qepd_cordic.sv]
// ----------------------------------------------------------------------------
// qepd_cordic
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qepd_cordic #(
	parameter int ITERATIONS = qepd_pkg::CORDIC_ITER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [qepd_pkg::VEC_W-1:0]   y_in,
	input  logic signed [qepd_pkg::VEC_W-1:0]   x_in,
	output logic                                done,
	output logic signed [qepd_pkg::ANG_W-1:0]   angle
);
	import qepd_pkg::*;

	localparam int NIT = (ITERATIONS > CORDIC_ITER_MAX) ? CORDIC_ITER_MAX : ITERATIONS;
	localparam int CW  = VEC_W + 2;

	logic signed [CW-1:0]    x_q, y_q, xs, ys, dx, dy;
	logic signed [ANG_W-1:0] z_q, at;
	logic [4:0]              it_q;
	logic                    busy_q, done_q;

	assign xs    = CW'(x_in);
	assign ys    = CW'(y_in);
	assign dx    = x_q >>> it_q;
	assign dy    = y_q >>> it_q;
	assign at    = atan_q30(it_q);
	assign done  = done_q;
	assign angle = z_q;

	// Pre-rotate into the right half plane, then rotate y toward zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else if (start) begin
			it_q <= '0;
			if (x_in == '0 && y_in == '0) begin
				z_q    <= '0;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				if (x_in < 0) begin
					if (y_in >= 0) begin
						x_q <= ys;
						y_q <= -xs;
						z_q <= HALF_PI_Q30;
					end else begin
						x_q <= -ys;
						y_q <= xs;
						z_q <= -HALF_PI_Q30;
					end
				end else begin
					x_q <= xs;
					y_q <= ys;
					z_q <= '0;
				end
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + dy;
				y_q <= y_q - dx;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dy;
				y_q <= y_q + dx;
				z_q <= z_q - at;
			end
			it_q <= it_q + 5'd1;
			if (it_q == 5'(NIT - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/quaternion_euler_pose_decoder_core.sv]
// ----------------------------------------------------------------------------
// quaternion_euler_pose_decoder_core
// Decodes armband notifications into held roll/pitch/yaw, pose buttons and
// battery level, one result word for every input word.
//
//   channel   dir  data                                   side band
//   s_axis    in   len,w,x,y,z,event_kind,pose,battery    tuser = func
//   m_axis    out  roll,pitch,yaw,buttons,batt,chg,rdy    -
//   cfg       in   session_started                        cfg_we strobe
//
// An IMU word holds the input from accept until its result word is loaded:
// nine products and one square on a shared multiplier, 29 root steps, then
// three CORDIC runs of N steps (none for a zero vector), each scaled by a
// reciprocal multiply and one correction step. Other words go straight to
// the output load, which waits only for the output register to be free.
// tready is high only while the sequencer is idle; a finished word waits in
// the output register, so the next word is taken while it is held.
// Reset clears held values, ready flag and session bit; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quaternion_euler_pose_decoder_core #(
	parameter int CORDIC_ITERATIONS = qepd_pkg::CORDIC_ITER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// length[4:0] w[20:5] x[36:21] y[52:37] z[68:53] event_kind[76:69]
	// pose_code[92:77] battery_byte[100:93] zero[103:101]
	input  logic [103:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// roll[15:0] pitch[31:16] yaw[47:32] button_mask[52:48]
	// battery_percent[59:53] changed[60] ready_res[61] zero[63:62]
	output logic [63:0]  m_axis_tdata
);
	import qepd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_SQRT, S_CGO, S_CWAIT, S_DIV, S_FIN, S_DONE
	} state_t;

	localparam logic [56:0] TWO_56 = 57'd1 << 56;
	// floor(32767 * 2^47 / pi_Q30)
	localparam logic [30:0] SCALE_RECIP = 31'((64'd32767 << 47) / 64'(PI_Q30));

	state_t state_q;

	// Input fields
	logic [4:0]         in_len;
	logic signed [15:0] in_w, in_x, in_y, in_z;
	logic [7:0]         in_kind, in_batt;
	logic [15:0]        in_pose;
	logic               s_acc;

	assign in_len  = s_axis_tdata[4:0];
	assign in_w    = s_axis_tdata[20:5];
	assign in_x    = s_axis_tdata[36:21];
	assign in_y    = s_axis_tdata[52:37];
	assign in_z    = s_axis_tdata[68:53];
	assign in_kind = s_axis_tdata[76:69];
	assign in_pose = s_axis_tdata[92:77];
	assign in_batt = s_axis_tdata[100:93];
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// Held state
	logic signed [15:0] angle_q [3];
	logic signed [15:0] na_q [3];
	logic [4:0]         buttons_q;
	logic [6:0]         battery_q;
	logic               ready_q, session_q, changed_q;
	logic [63:0]        out_q;
	logic               m_valid_q;

	// Quaternion and product registers
	logic signed [15:0] w_q, x_q, y_q, z_q;
	logic [3:0]         cnt_q;
	logic signed [59:0] prod_q, mul_p;
	logic signed [29:0] mul_a, mul_b, s_clamp, s_q;
	logic signed [31:0] p;
	logic signed [32:0] acc_s_q, num1_q, sq1_q, num2_q, sq2_q;
	logic signed [33:0] s_full;

	// Square root registers
	logic [56:0] rem_q, res_q, bit_q;
	logic [57:0] trial_sq;

	// CORDIC hookup and scaling
	logic                    cord_start, cord_done;
	logic signed [VEC_W-1:0] cord_x, cord_y;
	logic signed [ANG_W-1:0] cord_ang;
	logic [1:0]              ang_q;
	logic [33:0]             amag;
	logic [62:0]             qest_p;
	logic [31:0]             amag_q;
	logic [46:0]             dnum;
	logic [48:0]             qmul, drem;
	logic [16:0]             dq_q;
	logic                    dneg_q;
	logic signed [15:0]      fin_val;

	// Classifier decode
	logic       evt_valid, evt_commit;
	logic [4:0] evt_nb;
	logic [6:0] batt_nb;

	always_comb begin
		evt_valid  = 1'b0;
		evt_commit = 1'b0;
		evt_nb     = '0;
		unique case (in_kind)
			EVK_SYNCED, EVK_UNLOCKED, EVK_SYNC_FAILED: evt_valid = 1'b1;
			EVK_UNSYNCED, EVK_LOCKED: begin
				evt_valid  = 1'b1;
				evt_commit = 1'b1;
			end
			EVK_POSE: begin
				if (in_pose == POSE_REST || in_pose == POSE_UNKNOWN) begin
					evt_valid  = 1'b1;
					evt_commit = 1'b1;
				end else if (in_pose >= POSE_FIRST && in_pose <= POSE_LAST) begin
					evt_valid  = 1'b1;
					evt_commit = 1'b1;
					evt_nb     = 5'b00001 << (in_pose[2:0] - 3'd1);
				end
			end
			default: ;
		endcase
	end

	assign batt_nb = (in_batt > 8'(BATT_MAX)) ? BATT_MAX : in_batt[6:0];

	// Shared multiplier operand select
	assign s_full  = {acc_s_q, 1'b0};
	assign s_clamp = (s_full > ONE_Q28) ? 30'(ONE_Q28) :
	                 (s_full < -ONE_Q28) ? 30'(-ONE_Q28) : 30'(s_full);

	always_comb begin
		unique case (cnt_q)
			4'd0: begin mul_a = 30'(w_q); mul_b = 30'(y_q); end
			4'd1: begin mul_a = 30'(z_q); mul_b = 30'(x_q); end
			4'd2: begin mul_a = 30'(w_q); mul_b = 30'(x_q); end
			4'd3: begin mul_a = 30'(y_q); mul_b = 30'(z_q); end
			4'd4: begin mul_a = 30'(x_q); mul_b = 30'(x_q); end
			4'd5: begin mul_a = 30'(y_q); mul_b = 30'(y_q); end
			4'd6: begin mul_a = 30'(w_q); mul_b = 30'(z_q); end
			4'd7: begin mul_a = 30'(x_q); mul_b = 30'(y_q); end
			4'd8: begin mul_a = 30'(z_q); mul_b = 30'(z_q); end
			4'd9: begin mul_a = s_clamp;  mul_b = s_clamp;  end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign p        = prod_q[31:0];
	assign trial_sq = 58'(res_q) + 58'(bit_q);

	// CORDIC operands by angle: roll, pitch, yaw
	always_comb begin
		unique case (ang_q)
			2'd0: begin
				cord_y = {num1_q, 1'b0};
				cord_x = ONE_Q28 - {sq1_q, 1'b0};
			end
			2'd1: begin
				cord_y = VEC_W'(s_q);
				cord_x = VEC_W'(res_q[28:0]);
			end
			default: begin
				cord_y = {num2_q, 1'b0};
				cord_x = ONE_Q28 - {sq2_q, 1'b0};
			end
		endcase
	end

	assign cord_start = (state_q == S_CGO);

	qepd_cordic #(
		.ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.y_in   (cord_y),
		.x_in   (cord_x),
		.done   (cord_done),
		.angle  (cord_ang)
	);

	// Scale angle by 32767/pi: reciprocal estimate, then one correction step
	assign amag    = (cord_ang < 0) ? 34'(-cord_ang) : 34'(cord_ang);
	assign qest_p  = 63'(amag[31:0]) * 63'(SCALE_RECIP);
	assign dnum    = {amag_q, 15'b0} - 47'(amag_q);
	assign qmul    = 49'(dq_q) * 49'(PI_Q30);
	assign drem    = 49'(dnum) - qmul;
	assign fin_val = dneg_q ? ((dq_q > 17'd32768) ? -16'sd32768 : 16'(17'd0 - dq_q)) :
	                          ((dq_q > 17'd32767) ? 16'sd32767 : 16'(dq_q));

	// Sequencer, held state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			for (int k = 0; k < 3; k++) begin
				angle_q[k] <= '0;
				na_q[k]    <= '0;
			end
			buttons_q <= '0;
			battery_q <= '0;
			ready_q   <= 1'b0;
			session_q <= 1'b0;
			changed_q <= 1'b0;
			out_q     <= '0;
			m_valid_q <= 1'b0;
			w_q <= '0; x_q <= '0; y_q <= '0; z_q <= '0;
			cnt_q <= '0; prod_q <= '0; s_q <= '0;
			acc_s_q <= '0; num1_q <= '0; sq1_q <= '0; num2_q <= '0; sq2_q <= '0;
			rem_q <= '0; res_q <= '0; bit_q <= '0;
			ang_q <= '0; amag_q <= '0; dq_q <= '0; dneg_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				session_q <= cfg_wdata;
			end
			// Drop the taken word unless a new one loads this cycle
			if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						w_q <= in_w; x_q <= in_x; y_q <= in_y; z_q <= in_z;
						cnt_q     <= '0;
						ang_q     <= '0;
						if (s_axis_tuser == FUNC_IMU && in_len >= IMU_MIN_LEN) begin
							if (session_q) ready_q <= 1'b1;
							changed_q <= 1'b0;
							state_q   <= S_MUL;
						end else if (s_axis_tuser == FUNC_EVENT && in_len >= EVT_MIN_LEN) begin
							if (evt_valid && session_q) ready_q <= 1'b1;
							if (evt_commit) buttons_q <= evt_nb;
							changed_q <= evt_commit && (evt_nb != buttons_q);
							state_q   <= S_DONE;
						end else if (s_axis_tuser == FUNC_BATT && in_len != 5'd0) begin
							battery_q <= batt_nb;
							changed_q <= (batt_nb != battery_q);
							state_q   <= S_DONE;
						end else begin
							changed_q <= 1'b0;
							state_q   <= S_DONE;
						end
					end
				end
				S_MUL: begin
					// Multiply this step, accumulate the previous one
					prod_q <= mul_p;
					cnt_q  <= cnt_q + 4'd1;
					if (cnt_q == 4'd9) s_q <= s_clamp;
					unique case (cnt_q)
						4'd1: acc_s_q <= 33'(p);
						4'd2: acc_s_q <= acc_s_q - 33'(p);
						4'd3: num1_q  <= 33'(p);
						4'd4: num1_q  <= num1_q + 33'(p);
						4'd5: sq1_q   <= 33'(p);
						4'd6: begin
							sq1_q <= sq1_q + 33'(p);
							sq2_q <= 33'(p);
						end
						4'd7: num2_q  <= 33'(p);
						4'd8: num2_q  <= num2_q + 33'(p);
						4'd9: sq2_q   <= sq2_q + 33'(p);
						4'd10: begin
							rem_q   <= TWO_56 - prod_q[56:0];
							res_q   <= '0;
							bit_q   <= TWO_56;
							state_q <= S_SQRT;
						end
						default: ;
					endcase
				end
				S_SQRT: begin
					// One result bit per cycle
					if ({1'b0, rem_q} >= trial_sq) begin
						rem_q <= 57'({1'b0, rem_q} - trial_sq);
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) state_q <= S_CGO;
				end
				S_CGO: state_q <= S_CWAIT;
				S_CWAIT: begin
					// Take the angle magnitude and a quotient estimate low by at most one
					if (cord_done) begin
						amag_q  <= amag[31:0];
						dq_q    <= {1'b0, qest_p[62:47]};
						dneg_q  <= (cord_ang < 0);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (drem >= 49'(PI_Q30)) dq_q <= dq_q + 17'd1;
					state_q <= S_FIN;
				end
				S_FIN: begin
					na_q[ang_q] <= fin_val;
					if (ang_q == 2'd2) begin
						angle_q[0] <= na_q[0];
						angle_q[1] <= na_q[1];
						angle_q[2] <= fin_val;
						changed_q  <= (na_q[0] != angle_q[0]) || (na_q[1] != angle_q[1]) ||
						              (fin_val != angle_q[2]);
						state_q    <= S_DONE;
					end else begin
						ang_q   <= ang_q + 2'd1;
						state_q <= S_CGO;
					end
				end
				S_DONE: begin
					// Load the output word once the register is free
					if (!m_valid_q || m_axis_tready) begin
						out_q <= {2'b00, ready_q, changed_q, battery_q, buttons_q,
						          angle_q[2], angle_q[1], angle_q[0]};
						m_valid_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	`ASSERT_ALWAYS(a_batt_sat, clk, arst_n, battery_q <= BATT_MAX, "battery above ceiling")
	`ASSERT_ALWAYS(a_btn_hot, clk, arst_n, $onehot0(buttons_q), "more than one pose button")
	`ASSERT_NEXT(a_ready_sticky, clk, arst_n, ready_q, ready_q, "ready flag dropped")
	`ASSERT_IMPL(a_out_from_done, clk, arst_n, $rose(m_valid_q), $past(state_q == S_DONE), "output word without finish")
	`ASSERT_IMPL(a_busy_no_in, clk, arst_n, state_q != S_IDLE, !s_acc, "word taken while busy")

endmodule

`default_nettype wire

[tb/qepd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qepd_checker
// Watches the input, result and config channels of the pose decoder, models
// the held angles, buttons, battery and ready flag, and compares every
// result word against the oldest predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module qepd_checker #(
	parameter int CORDIC_ITERATIONS = qepd_pkg::CORDIC_ITER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_wdata,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,
	output int           fail_count,
	output int           pending,
	output int           words_checked,
	output int           imu_words
);
	import qepd_pkg::*;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic [4:0]         buttons;
		logic [6:0]         battery;
		logic               changed;
		logic               ready;
	} pose_word_t;

	localparam longint ONE28  = 64'sd268435456;
	localparam longint PI30   = 64'sd3373259426;
	localparam longint HPI30  = 64'sd1686629713;

	// floored arctan(2^-i) in Q2.30
	localparam longint ATAN_TAB [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	pose_word_t          pose_word_q [$];
	logic signed [15:0]  held_angle [3];
	logic [4:0]          held_buttons;
	logic [6:0]          held_battery;
	logic                held_ready;
	logic                session_on;

	// floor square root of a 64-bit value
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v)
			probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return res;
	endfunction

	// vectoring CORDIC, angle in Q2.30
	function automatic longint vector_angle(input longint y, input longint x);
		longint z;
		longint t;
		longint dx;
		longint dy;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = HPI30;
			end else begin
				t = x; x = -y; y = t; z = -HPI30;
			end
		end
		for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
			end else begin
				x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	// scale Q2.30 radians to the 16-bit axis range, truncate and clamp
	function automatic logic signed [15:0] axis_scale(input longint a);
		longint q;
		q = (a * 32767) / PI30;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	// advance the held state by one notification and return the result word
	function automatic pose_word_t decode_word(input logic [103:0] d, input logic [1:0] fn);
		pose_word_t         r;
		logic [4:0]         len;
		longint             w, x, y, z, num, den, s, c;
		logic signed [15:0] na [3];
		logic [7:0]         kind;
		logic [15:0]        pose;
		logic [7:0]         bb;
		logic [6:0]         nbat;
		logic [4:0]         nb;
		logic               valid, commit, chg;
		len = d[4:0];
		valid = 1'b0;
		commit = 1'b0;
		chg = 1'b0;
		nb = '0;
		if (func_t'(fn) == FUNC_IMU && len >= IMU_MIN_LEN) begin
			w = longint'($signed(d[20:5]));
			x = longint'($signed(d[36:21]));
			y = longint'($signed(d[52:37]));
			z = longint'($signed(d[68:53]));
			num = 2 * (w * x + y * z);
			den = ONE28 - 2 * (x * x + y * y);
			na[0] = axis_scale(vector_angle(num, den));
			s = 2 * (w * y - z * x);
			if (s > ONE28)
				s = ONE28;
			if (s < -ONE28)
				s = -ONE28;
			c = longint'(root_floor(ONE28 * ONE28 - s * s));
			na[1] = axis_scale(vector_angle(s, c));
			num = 2 * (w * z + x * y);
			den = ONE28 - 2 * (y * y + z * z);
			na[2] = axis_scale(vector_angle(num, den));
			for (int k = 0; k < 3; k++) begin
				if (na[k] != held_angle[k])
					chg = 1'b1;
				held_angle[k] = na[k];
			end
			valid = 1'b1;
		end else if (func_t'(fn) == FUNC_EVENT && len >= EVT_MIN_LEN) begin
			kind = d[76:69];
			pose = d[92:77];
			if (kind == EVK_SYNCED || kind == EVK_UNLOCKED || kind == EVK_SYNC_FAILED) begin
				valid = 1'b1;
			end else if (kind == EVK_UNSYNCED || kind == EVK_LOCKED) begin
				valid = 1'b1; commit = 1'b1;
			end else if (kind == EVK_POSE) begin
				if (pose == POSE_REST || pose == POSE_UNKNOWN) begin
					valid = 1'b1; commit = 1'b1;
				end else if (pose >= POSE_FIRST && pose <= POSE_LAST) begin
					valid = 1'b1; commit = 1'b1;
					nb = 5'd1 << (pose - 1);
				end
			end
			if (commit) begin
				chg = (nb != held_buttons);
				held_buttons = nb;
			end
		end else if (func_t'(fn) == FUNC_BATT && len >= 1) begin
			bb = d[100:93];
			nbat = (bb > BATT_MAX) ? BATT_MAX : bb[6:0];
			chg = (nbat != held_battery);
			held_battery = nbat;
		end
		if (valid && session_on)
			held_ready = 1'b1;
		r.roll = held_angle[0];
		r.pitch = held_angle[1];
		r.yaw = held_angle[2];
		r.buttons = held_buttons;
		r.battery = held_battery;
		r.changed = chg;
		r.ready = held_ready;
		return r;
	endfunction

	// track config, predict on accepted input, compare accepted output
	always @(posedge clk or negedge arst_n) begin
		pose_word_t got;
		pose_word_t want;
		if (!arst_n) begin
			held_angle[0] = '0;
			held_angle[1] = '0;
			held_angle[2] = '0;
			held_buttons = '0;
			held_battery = '0;
			held_ready = 1'b0;
			session_on = 1'b0;
			fail_count <= 0;
			pending <= 0;
			words_checked <= 0;
			imu_words <= 0;
			pose_word_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.roll = m_axis_tdata[15:0];
				got.pitch = m_axis_tdata[31:16];
				got.yaw = m_axis_tdata[47:32];
				got.buttons = m_axis_tdata[52:48];
				got.battery = m_axis_tdata[59:53];
				got.changed = m_axis_tdata[60];
				got.ready = m_axis_tdata[61];
				words_checked <= words_checked + 1;
				if (pose_word_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result word %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = pose_word_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display({"ERROR: word %0d exp r=%0d p=%0d y=%0d b=%h bat=%0d ",
								"c=%b rdy=%b got r=%0d p=%0d y=%0d b=%h bat=%0d c=%b rdy=%b"},
								words_checked, want.roll, want.pitch, want.yaw, want.buttons,
								want.battery, want.changed, want.ready, got.roll, got.pitch,
								got.yaw, got.buttons, got.battery, got.changed, got.ready);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (func_t'(s_axis_tuser) == FUNC_IMU && s_axis_tdata[4:0] >= IMU_MIN_LEN)
					imu_words <= imu_words + 1;
				pose_word_q.push_back(decode_word(s_axis_tdata, s_axis_tuser));
			end
			if (cfg_we)
				session_on = cfg_wdata;
			pending <= pose_word_q.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_quaternion_euler_pose_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_euler_pose_decoder_core
// Drives directed and random armband notifications into the pose decoder
// with bursty input and a stalling receiver, toggles the session bit between
// phases, and lets the checker compare every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_euler_pose_decoder_core;
	import qepd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_wdata;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	int           fail_count;
	int           pending;
	int           words_checked;
	int           imu_words;
	int           burst_left;
	int           idle_cycles;

	quaternion_euler_pose_decoder_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	qepd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .fail_count(fail_count), .pending(pending),
		.words_checked(words_checked), .imu_words(imu_words)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: alternate between always-ready, random and long stall modes
	initial begin
		int mode;
		int span;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(8, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready = 1'b1;
					1: m_axis_tready = ($urandom_range(0, 3) != 0);
					default: m_axis_tready = ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	// watchdog: end the run after too long without any accepted word
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("ERROR: watchdog expired with %0d words pending", pending);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// send one notification word; called at a falling edge, returns at one
	task automatic send_note(input func_t fn, input logic [4:0] len,
		input logic [15:0] w, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z, input logic [7:0] kind, input logic [15:0] pose,
		input logic [7:0] batt);
		if (burst_left == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tuser = fn;
		s_axis_tdata = {3'b000, batt, pose, kind, z, y, x, w, len};
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_imu(input logic [15:0] w, input logic [15:0] x,
		input logic [15:0] y, input logic [15:0] z);
		send_note(FUNC_IMU, IMU_MIN_LEN, w, x, y, z, 8'h00, 16'h0000, 8'h00);
	endtask

	task automatic send_event(input logic [7:0] kind, input logic [15:0] pose);
		send_note(FUNC_EVENT, EVT_MIN_LEN, 16'h0, 16'h0, 16'h0, 16'h0, kind, pose, 8'h00);
	endtask

	// wait until every result is in and the block is idle, then write the bit
	task automatic set_session(input logic val);
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata = val;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// random notification, mostly well-formed with random content
	task automatic send_random();
		int pick;
		logic [4:0] len;
		logic [15:0] pose;
		logic [7:0] kind;
		pick = $urandom_range(0, 99);
		len = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 20)) : 5'd20;
		if (pick < 45) begin
			send_note(FUNC_IMU, len, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
		end else if (pick < 80) begin
			kind = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: pose = POSE_UNKNOWN;
				1: pose = 16'($urandom);
				default: pose = 16'($urandom_range(0, 6));
			endcase
			send_note(FUNC_EVENT, len, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), kind, pose, 8'($urandom));
		end else if (pick < 95) begin
			send_note(FUNC_BATT, 5'($urandom_range(0, 20)), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
		end else begin
			send_note(FUNC_OTHER, len, 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_IMU;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: session off, so valid items must not set ready
		send_imu(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		send_event(EVK_SYNCED, POSE_REST);
		set_session(1'b1);
		// short IMU packet is ignored and leaves ready alone
		send_note(FUNC_IMU, 5'd19, 16'h2D41, 16'h2D41, 16'h0000, 16'h0000,
			8'h00, 16'h0, 8'h00);
		send_imu(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
		send_imu(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
		send_imu(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_imu(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_imu(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_imu(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		send_imu(16'h0000, 16'h0000, 16'h0000, 16'hC000);
		for (int p = 1; p <= 5; p++)
			send_event(EVK_POSE, 16'(p));
		send_event(EVK_POSE, POSE_UNKNOWN);
		send_event(EVK_POSE, 16'd3);
		send_event(EVK_POSE, 16'd6);
		send_event(8'd0, 16'd2);
		send_event(EVK_UNSYNCED, 16'd0);
		send_event(EVK_POSE, 16'd1);
		send_event(EVK_LOCKED, 16'd0);
		send_event(EVK_UNLOCKED, 16'd0);
		send_event(EVK_SYNC_FAILED, 16'd0);
		send_event(EVK_POSE, POSE_REST);
		send_note(FUNC_EVENT, 5'd2, 16'h0, 16'h0, 16'h0, 16'h0, EVK_POSE, 16'd2, 8'h0);
		send_note(FUNC_BATT, 5'd1, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 8'hFF);
		send_note(FUNC_BATT, 5'd0, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 8'd40);
		send_note(FUNC_BATT, 5'd1, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 8'd100);
		send_note(FUNC_OTHER, 5'd20, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 16'h0, 8'd7);

		// random phases with the session bit toggled, ready must stay set
		set_session(1'b0);
		repeat (275) send_random();
		set_session(1'b1);
		repeat (275) send_random();
		set_session(1'b0);
		repeat (275) send_random();
		set_session(1'b1);
		repeat (275) send_random();

		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Checked %0d result words, %0d of them from full IMU packets,", words_checked,
			imu_words);
		$display("across four session-bit phases; %0d mismatches.", fail_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

[quaternion_euler_pose_decoder_core.f]
+incdir+rtl
rtl/qepd_pkg.sv
rtl/qepd_cordic.sv
rtl/quaternion_euler_pose_decoder_core.sv
tb/qepd_checker.sv
tb/tb_quaternion_euler_pose_decoder_core.sv
